// ----- sv/efd_pkg.sv -----
// Package for the Easter and feast date block.
// Holds the date type, the range limits, the reciprocal constants and the
// date placement function. Depends on nothing.
package efd_pkg;

    typedef struct packed {
        logic [3:0] mon;
        logic [4:0] dom;
    } date_t;

    localparam logic [13:0] YEAR_FIRST = 14'd1583;
    localparam logic [13:0] YEAR_LAST  = 14'd9999;

    // Reciprocals scaled by a power of two, exact over the ranges used.
    localparam logic [15:0] RECIP_100 = 16'd10486;  // 2^20 / 100
    localparam logic [15:0] RECIP_19  = 16'd55189;  // 2^20 / 19
    localparam logic [6:0]  RECIP_25  = 7'd41;      // 2^10 / 25
    localparam logic [8:0]  RECIP_3   = 9'd171;     // 2^9 / 3
    localparam logic [11:0] RECIP_30  = 12'd2185;   // 2^16 / 30
    localparam logic [8:0]  RECIP_7   = 9'd293;     // 2^11 / 7

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;

    // Days from March 1 to the first of April, May, June and July.
    localparam logic signed [7:0] START_APR = 8'sd31;
    localparam logic signed [7:0] START_MAY = 8'sd61;
    localparam logic signed [7:0] START_JUN = 8'sd92;
    localparam logic signed [7:0] START_JUL = 8'sd122;

    // Turns a day offset from March 1 into a month and a day of month.
    function automatic date_t place_date(logic signed [7:0] off, logic [4:0] feb_len);
        date_t             res;
        logic signed [7:0] dom_wide;
        begin
            if (off < 8'sd0)
            begin
                res.mon  = MON_FEB;
                dom_wide = $signed({3'b000, feb_len}) + off + 8'sd1;
            end
            else if (off >= START_JUL)
            begin
                res.mon  = MON_JUL;
                dom_wide = off - START_JUL + 8'sd1;
            end
            else if (off >= START_JUN)
            begin
                res.mon  = MON_JUN;
                dom_wide = off - START_JUN + 8'sd1;
            end
            else if (off >= START_MAY)
            begin
                res.mon  = MON_MAY;
                dom_wide = off - START_MAY + 8'sd1;
            end
            else if (off >= START_APR)
            begin
                res.mon  = MON_APR;
                dom_wide = off - START_APR + 8'sd1;
            end
            else
            begin
                res.mon  = MON_MAR;
                dom_wide = off + 8'sd1;
            end
            res.dom = dom_wide[4:0];
            return res;
        end
    endfunction

endpackage

// ----- sv/easter_and_feast_dates.sv -----
// Top level of the Easter and feast date block: a ten stage pipeline.
// Depends on efd_pkg for the date type, constants and date placement.
//
// Usage: drive year_in and pulse start for one cycle per year. busy is
// always low, so a year is taken at every rising edge where start is high,
// one year per cycle without gaps. When a year leaves the last stage, done
// is high for exactly one cycle with year_ok, the Easter Sunday date and
// the carnival, Good Friday, Ascension and Whitsuntide dates, each as a
// month and a day of month. Results leave in the order the years came in.
// Throughput is one year per cycle. The depth is set by the chain of
// constant divisions of the computus; each remainder takes a reciprocal
// multiply followed by a multiply and subtract in the next stage.
// Years outside 1583 to 9999 give year_ok low and all date fields zero.
// Reset clears the valid bits of every stage, so no beat leaves after
// reset until a new year is taken. The receiver cannot hold results off,
// so the pipeline never stalls.
module easter_and_feast_dates (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [13:0] year_in,
    output logic        busy,
    output logic        done,
    output logic        year_ok,
    output logic [3:0]  easter_mon,
    output logic [4:0]  easter_dom,
    output logic [3:0]  carnival_mon,
    output logic [4:0]  carnival_dom,
    output logic [3:0]  good_friday_mon,
    output logic [4:0]  good_friday_dom,
    output logic [3:0]  ascension_mon,
    output logic [4:0]  ascension_dom,
    output logic [3:0]  whitsun_mon,
    output logic [4:0]  whitsun_dom
);

    import efd_pkg::*;

    localparam int NUM_STAGES = 10;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;

    // Stage 1
    logic [27:0] prod_cent;
    logic [29:0] prod_19;
    logic [13:0] y1_reg, y1_next;
    logic [7:0]  b1_reg, b1_next;
    logic [9:0]  q19_1_reg, q19_1_next;
    logic        ok1_reg, ok1_next;

    // Stage 2
    logic [13:0] a_wide, c_wide;
    logic [8:0]  b_plus8;
    logic [14:0] prod_f;
    logic [4:0]  a2_reg, a2_next;
    logic [7:0]  b2_reg, b2_next;
    logic [6:0]  c2_reg, c2_next;
    logic [4:0]  f2_reg, f2_next;
    logic        leap2_reg, leap2_next;
    logic        ok2_reg, ok2_next;

    // Stage 3
    logic [8:0]  g_arg;
    logic [16:0] prod_g;
    logic [4:0]  a3_reg, a3_next;
    logic [7:0]  b3_reg, b3_next;
    logic [5:0]  d3_reg, d3_next;
    logic [5:0]  g3_reg, g3_next;
    logic [6:0]  p3_reg, p3_next;
    logic        leap3_reg, leap3_next;
    logic        ok3_reg, ok3_next;

    // Stage 4
    logic [9:0]  xh;
    logic [21:0] prod_qh;
    logic [9:0]  xh4_reg, xh4_next;
    logic [4:0]  qh4_reg, qh4_next;
    logic [4:0]  a4_reg, a4_next;
    logic [6:0]  p4_reg, p4_next;
    logic        leap4_reg, leap4_next;
    logic        ok4_reg, ok4_next;

    // Stage 5
    logic [9:0]  h_wide;
    logic [4:0]  h5_reg, h5_next;
    logic [4:0]  a5_reg, a5_next;
    logic [6:0]  p5_reg, p5_next;
    logic        leap5_reg, leap5_next;
    logic        ok5_reg, ok5_next;

    // Stage 6
    logic [6:0]  xl;
    logic [15:0] prod_ql;
    logic [6:0]  xl6_reg, xl6_next;
    logic [4:0]  ql6_reg, ql6_next;
    logic [4:0]  h6_reg, h6_next;
    logic [4:0]  a6_reg, a6_next;
    logic        leap6_reg, leap6_next;
    logic        ok6_reg, ok6_next;

    // Stage 7
    logic [6:0]  l_wide;
    logic [2:0]  l7_reg, l7_next;
    logic [4:0]  h7_reg, h7_next;
    logic [4:0]  a7_reg, a7_next;
    logic        leap7_reg, leap7_next;
    logic        ok7_reg, ok7_next;

    // Stage 8
    logic [8:0]  m_sum;
    logic        m_bit;
    logic [5:0]  eoff8_reg, eoff8_next;
    logic        leap8_reg, leap8_next;
    logic        ok8_reg, ok8_next;

    // Stage 9
    logic signed [7:0] eoff_s;
    date_t             easter9_reg, easter9_next;
    logic signed [7:0] offc9_reg, offc9_next;
    logic signed [7:0] offg9_reg, offg9_next;
    logic signed [7:0] offa9_reg, offa9_next;
    logic signed [7:0] offw9_reg, offw9_next;
    logic [4:0]        feb9_reg, feb9_next;
    logic              ok9_reg, ok9_next;

    // Stage 10, the output registers
    date_t easter_reg, easter_next;
    date_t carn_reg, carn_next;
    date_t gfri_reg, gfri_next;
    date_t asc_reg, asc_next;
    date_t whit_reg, whit_next;
    logic  ok_reg, ok_next;

    assign vld_next = {vld_reg[NUM_STAGES-2:0], start & ~busy};

    always_comb
    begin
        prod_cent  = {14'd0, year_in} * {12'd0, RECIP_100};
        prod_19    = {16'd0, year_in} * {14'd0, RECIP_19};
        y1_next    = year_in;
        b1_next    = prod_cent[27:20];
        q19_1_next = prod_19[29:20];
        ok1_next   = (year_in >= YEAR_FIRST) && (year_in <= YEAR_LAST);
    end

    always_comb
    begin
        a_wide     = y1_reg - ({4'd0, q19_1_reg} * 14'd19);
        c_wide     = y1_reg - ({6'd0, b1_reg} * 14'd100);
        b_plus8    = {1'b0, b1_reg} + 9'd8;
        prod_f     = {6'd0, b_plus8} * {8'd0, RECIP_25};
        a2_next    = a_wide[4:0];
        b2_next    = b1_reg;
        c2_next    = c_wide[6:0];
        f2_next    = prod_f[14:10];
        leap2_next = (y1_reg[1:0] == 2'd0)
                   && ((c_wide[6:0] != 7'd0) || (b1_reg[1:0] == 2'd0));
        ok2_next   = ok1_reg;
    end

    always_comb
    begin
        g_arg      = {1'b0, b2_reg} - {4'd0, f2_reg} + 9'd1;
        prod_g     = {8'd0, g_arg} * {8'd0, RECIP_3};
        a3_next    = a2_reg;
        b3_next    = b2_reg;
        d3_next    = b2_reg[7:2];
        g3_next    = prod_g[14:9];
        p3_next    = 7'd32 + {4'd0, b2_reg[1:0], 1'b0} + {1'b0, c2_reg[6:2], 1'b0}
                   - {5'd0, c2_reg[1:0]};
        leap3_next = leap2_reg;
        ok3_next   = ok2_reg;
    end

    always_comb
    begin
        xh         = ({5'd0, a3_reg} * 10'd19) + {2'd0, b3_reg} - {4'd0, d3_reg}
                   - {4'd0, g3_reg} + 10'd15;
        prod_qh    = {12'd0, xh} * {10'd0, RECIP_30};
        xh4_next   = xh;
        qh4_next   = prod_qh[20:16];
        a4_next    = a3_reg;
        p4_next    = p3_reg;
        leap4_next = leap3_reg;
        ok4_next   = ok3_reg;
    end

    always_comb
    begin
        h_wide     = xh4_reg - ({5'd0, qh4_reg} * 10'd30);
        h5_next    = h_wide[4:0];
        a5_next    = a4_reg;
        p5_next    = p4_reg;
        leap5_next = leap4_reg;
        ok5_next   = ok4_reg;
    end

    always_comb
    begin
        xl         = p5_reg - {2'd0, h5_reg};
        prod_ql    = {9'd0, xl} * {7'd0, RECIP_7};
        xl6_next   = xl;
        ql6_next   = prod_ql[15:11];
        h6_next    = h5_reg;
        a6_next    = a5_reg;
        leap6_next = leap5_reg;
        ok6_next   = ok5_reg;
    end

    always_comb
    begin
        l_wide     = xl6_reg - ({2'd0, ql6_reg} * 7'd7);
        l7_next    = l_wide[2:0];
        h7_next    = h6_reg;
        a7_next    = a6_reg;
        leap7_next = leap6_reg;
        ok7_next   = ok6_reg;
    end

    // Easter as a day offset from March 1: h + l - 7m + 114 - 93.
    always_comb
    begin
        m_sum      = {4'd0, a7_reg} + ({4'd0, h7_reg} * 9'd11) + ({6'd0, l7_reg} * 9'd22);
        m_bit      = (m_sum >= 9'd451);
        eoff8_next = {1'b0, h7_reg} + {3'd0, l7_reg} + 6'd21 - (m_bit ? 6'd7 : 6'd0);
        leap8_next = leap7_reg;
        ok8_next   = ok7_reg;
    end

    always_comb
    begin
        eoff_s = $signed({2'b00, eoff8_reg});
        if (eoff8_reg < 6'd31)
        begin
            easter9_next.mon = MON_MAR;
            easter9_next.dom = eoff8_reg[4:0] + 5'd1;
        end
        else
        begin
            easter9_next.mon = MON_APR;
            easter9_next.dom = 5'(eoff8_reg - 6'd30);
        end
        offc9_next = eoff_s - 8'sd49;
        offg9_next = eoff_s - 8'sd2;
        offa9_next = eoff_s + 8'sd39;
        offw9_next = eoff_s + 8'sd49;
        feb9_next  = leap8_reg ? 5'd29 : 5'd28;
        ok9_next   = ok8_reg;
    end

    always_comb
    begin
        ok_next = ok9_reg;
        if (ok9_reg)
        begin
            easter_next = easter9_reg;
            carn_next   = place_date(offc9_reg, feb9_reg);
            gfri_next   = place_date(offg9_reg, feb9_reg);
            asc_next    = place_date(offa9_reg, feb9_reg);
            whit_next   = place_date(offw9_reg, feb9_reg);
        end
        else
        begin
            easter_next = '0;
            carn_next   = '0;
            gfri_next   = '0;
            asc_next    = '0;
            whit_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y1_reg      <= y1_next;
        b1_reg      <= b1_next;
        q19_1_reg   <= q19_1_next;
        ok1_reg     <= ok1_next;
        a2_reg      <= a2_next;
        b2_reg      <= b2_next;
        c2_reg      <= c2_next;
        f2_reg      <= f2_next;
        leap2_reg   <= leap2_next;
        ok2_reg     <= ok2_next;
        a3_reg      <= a3_next;
        b3_reg      <= b3_next;
        d3_reg      <= d3_next;
        g3_reg      <= g3_next;
        p3_reg      <= p3_next;
        leap3_reg   <= leap3_next;
        ok3_reg     <= ok3_next;
        xh4_reg     <= xh4_next;
        qh4_reg     <= qh4_next;
        a4_reg      <= a4_next;
        p4_reg      <= p4_next;
        leap4_reg   <= leap4_next;
        ok4_reg     <= ok4_next;
        h5_reg      <= h5_next;
        a5_reg      <= a5_next;
        p5_reg      <= p5_next;
        leap5_reg   <= leap5_next;
        ok5_reg     <= ok5_next;
        xl6_reg     <= xl6_next;
        ql6_reg     <= ql6_next;
        h6_reg      <= h6_next;
        a6_reg      <= a6_next;
        leap6_reg   <= leap6_next;
        ok6_reg     <= ok6_next;
        l7_reg      <= l7_next;
        h7_reg      <= h7_next;
        a7_reg      <= a7_next;
        leap7_reg   <= leap7_next;
        ok7_reg     <= ok7_next;
        eoff8_reg   <= eoff8_next;
        leap8_reg   <= leap8_next;
        ok8_reg     <= ok8_next;
        easter9_reg <= easter9_next;
        offc9_reg   <= offc9_next;
        offg9_reg   <= offg9_next;
        offa9_reg   <= offa9_next;
        offw9_reg   <= offw9_next;
        feb9_reg    <= feb9_next;
        ok9_reg     <= ok9_next;
        easter_reg  <= easter_next;
        carn_reg    <= carn_next;
        gfri_reg    <= gfri_next;
        asc_reg     <= asc_next;
        whit_reg    <= whit_next;
        ok_reg      <= ok_next;
    end

    assign busy            = 1'b0;
    assign done            = vld_reg[NUM_STAGES-1];
    assign year_ok         = ok_reg;
    assign easter_mon      = easter_reg.mon;
    assign easter_dom      = easter_reg.dom;
    assign carnival_mon    = carn_reg.mon;
    assign carnival_dom    = carn_reg.dom;
    assign good_friday_mon = gfri_reg.mon;
    assign good_friday_dom = gfri_reg.dom;
    assign ascension_mon   = asc_reg.mon;
    assign ascension_dom   = asc_reg.dom;
    assign whitsun_mon     = whit_reg.mon;
    assign whitsun_dom     = whit_reg.dom;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##10 done)
        else $error("result beat did not appear ten cycles after the year was taken");

    a_easter_month: assert property (@(posedge clk) disable iff (!rst_n)
        (done && year_ok) |-> ((easter_mon == MON_MAR) || (easter_mon == MON_APR)))
        else $error("Easter month is neither March nor April");

    a_no_day_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && year_ok) |-> ((carnival_dom != 5'd0) && (good_friday_dom != 5'd0)
                               && (easter_dom != 5'd0)))
        else $error("a feast date has day of month zero");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !year_ok) |-> ((easter_mon == 4'd0) && (easter_dom == 5'd0)
                                && (whitsun_mon == 4'd0) && (ascension_dom == 5'd0)))
        else $error("dates not zero for a year out of range");
`endif

endmodule
